@@ rtl/tvtg_pkg.sv @@
// ----------------------------------------------------------------------------
// tvtg_pkg
// Shared types, constants and rate tables for the three-voice tone generator.
// ----------------------------------------------------------------------------
package tvtg_pkg;

    localparam int VOICES      = 3;   // active voices, 1..3
    localparam int VOICE_SLOTS = 3;   // voice slots in the register map
    localparam int LEVEL_W     = 7;

    localparam logic [4:0] VOICE_STRIDE = 5'd7;
    localparam logic [4:0] FILTER_BASE  = 5'd21;   // filter registers: no effect

    // register offsets within a voice
    localparam logic [2:0] OFF_FREQ_LO = 3'd0;
    localparam logic [2:0] OFF_FREQ_HI = 3'd1;
    localparam logic [2:0] OFF_PW_LO   = 3'd2;
    localparam logic [2:0] OFF_PW_HI   = 3'd3;
    localparam logic [2:0] OFF_CTRL    = 3'd4;
    localparam logic [2:0] OFF_AD      = 3'd5;
    localparam logic [2:0] OFF_SR      = 3'd6;

    // control byte bits
    localparam int CTRL_GATE  = 0;
    localparam int CTRL_TEST  = 3;
    localparam int CTRL_TRI   = 4;
    localparam int CTRL_SAW   = 5;
    localparam int CTRL_PULSE = 6;

    // input word kinds (tuser)
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ENV_ATTACK  = 2'd0,
        ENV_DECAY   = 2'd1,
        ENV_SUSTAIN = 2'd2,
        ENV_RELEASE = 2'd3
    } env_stage_t;

    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [2:0] off;
        logic [7:0] data;
    } voice_cmd_t;

    function automatic logic [16:0] attack_period(input logic [3:0] idx);
        logic [16:0] p;
        case (idx)
            4'd0:    p = 17'd7;
            4'd1:    p = 17'd31;
            4'd2:    p = 17'd62;
            4'd3:    p = 17'd93;
            4'd4:    p = 17'd148;
            4'd5:    p = 17'd218;
            4'd6:    p = 17'd265;
            4'd7:    p = 17'd312;
            4'd8:    p = 17'd390;
            4'd9:    p = 17'd976;
            4'd10:   p = 17'd1953;
            4'd11:   p = 17'd3125;
            4'd12:   p = 17'd3906;
            4'd13:   p = 17'd11718;
            4'd14:   p = 17'd19531;
            default: p = 17'd31250;
        endcase
        return p;
    endfunction

    function automatic logic [16:0] decay_period(input logic [3:0] idx);
        logic [16:0] p;
        case (idx)
            4'd0:    p = 17'd23;
            4'd1:    p = 17'd93;
            4'd2:    p = 17'd187;
            4'd3:    p = 17'd281;
            4'd4:    p = 17'd445;
            4'd5:    p = 17'd656;
            4'd6:    p = 17'd796;
            4'd7:    p = 17'd937;
            4'd8:    p = 17'd1171;
            4'd9:    p = 17'd2929;
            4'd10:   p = 17'd5859;
            4'd11:   p = 17'd9375;
            4'd12:   p = 17'd11718;
            4'd13:   p = 17'd35156;
            4'd14:   p = 17'd58593;
            default: p = 17'd93750;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/tvtg_voice.sv @@
// ----------------------------------------------------------------------------
// tvtg_voice
// One voice: register bytes, phase accumulator, wave mixer and ADSR envelope.
// ----------------------------------------------------------------------------
module tvtg_voice
    import tvtg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  voice_cmd_t           cmd,
    output logic [LEVEL_W-1:0]   level
);

    logic [15:0] freq_reg,   freq_next;
    logic [11:0] pw_reg,     pw_next;
    logic [7:0]  ctrl_reg,   ctrl_next;
    logic [7:0]  ad_reg,     ad_next;
    logic [7:0]  sr_reg,     sr_next;
    logic [23:0] phase_reg,  phase_next;
    logic [7:0]  env_reg,    env_next;
    env_stage_t  stage_reg,  stage_next;
    logic        run_reg,    run_next;
    logic [16:0] count_reg,  count_next;
    logic [16:0] period_reg, period_next;

    logic [16:0] count_inc;
    logic [7:0]  env_inc;
    logic [7:0]  sustain;
    logic [11:0] top;
    logic [11:0] tri_wave;
    logic [11:0] pulse_wave;
    logic [11:0] mix;
    logic [19:0] product;
    logic [3:0]  scaled;

    assign sustain   = {sr_reg[7:4], 4'h0};
    assign count_inc = count_reg + 17'd1;
    assign env_inc   = env_reg + 8'd1;

    // next state
    always_comb begin
        freq_next   = freq_reg;
        pw_next     = pw_reg;
        ctrl_next   = ctrl_reg;
        ad_next     = ad_reg;
        sr_next     = sr_reg;
        phase_next  = phase_reg;
        env_next    = env_reg;
        stage_next  = stage_reg;
        run_next    = run_reg;
        count_next  = count_reg;
        period_next = period_reg;

        if (cmd.wr) begin
            case (cmd.off)
                OFF_FREQ_LO: freq_next[7:0]  = cmd.data;
                OFF_FREQ_HI: freq_next[15:8] = cmd.data;
                OFF_PW_LO:   pw_next[7:0]    = cmd.data;
                OFF_PW_HI:   pw_next[11:8]   = cmd.data[3:0];
                OFF_CTRL: begin
                    ctrl_next = cmd.data;
                    if (cmd.data[CTRL_GATE] != ctrl_reg[CTRL_GATE]) begin
                        if (cmd.data[CTRL_GATE]) begin
                            env_next    = 8'd0;
                            stage_next  = ENV_ATTACK;
                            count_next  = 17'd0;
                            period_next = attack_period(ad_reg[7:4]);
                        end else begin
                            stage_next  = ENV_RELEASE;
                            period_next = decay_period(sr_reg[3:0]);
                        end
                        run_next = 1'b1;
                    end
                    if (cmd.data[CTRL_TEST]) begin
                        phase_next = 24'hFFFFFF;
                    end
                end
                OFF_AD:  ad_next = cmd.data;
                OFF_SR:  sr_next = cmd.data;
                default: ;
            endcase
        end else if (cmd.tick) begin
            if (!ctrl_reg[CTRL_TEST]) begin
                phase_next = phase_reg + {8'd0, freq_reg};
            end
            if (run_reg) begin
                if (count_inc < period_reg) begin
                    count_next = count_inc;
                end else begin
                    count_next = 17'd0;
                    case (stage_reg)
                        ENV_ATTACK: begin
                            env_next = env_inc;
                            if (env_inc == 8'hFF) begin
                                stage_next  = ENV_DECAY;
                                period_next = decay_period(ad_reg[3:0]);
                            end
                        end
                        ENV_DECAY: begin
                            if (env_reg == sustain) begin
                                run_next   = 1'b0;
                                stage_next = ENV_SUSTAIN;
                            end else begin
                                env_next = env_reg - 8'd1;
                            end
                        end
                        ENV_SUSTAIN: stage_next = ENV_RELEASE;
                        default: begin
                            if (env_reg != 8'd0) begin
                                env_next = env_reg - 8'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // output level from the advanced phase and envelope
    always_comb begin
        top        = phase_next[23:12];
        pulse_wave = (top >= (12'hFFF - pw_reg)) ? 12'hFFF : 12'h000;
        tri_wave   = {top[10:0], 1'b0} ^ (phase_next[23] ? 12'hFFE : 12'h000);
        mix        = 12'hFFF;
        if (ctrl_reg[CTRL_TRI]) begin
            mix = mix & tri_wave;
        end
        if (ctrl_reg[CTRL_SAW]) begin
            mix = mix & top;
        end
        if (ctrl_reg[CTRL_PULSE]) begin
            mix = mix & pulse_wave;
        end
        if (!(ctrl_reg[CTRL_TRI] || ctrl_reg[CTRL_SAW] || ctrl_reg[CTRL_PULSE])) begin
            mix = 12'h000;
        end
        product = mix * env_next;
        scaled  = product[19:16];
        level   = {1'b0, scaled, 2'b00} + {3'b000, scaled};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg   <= '0;
            pw_reg     <= '0;
            ctrl_reg   <= '0;
            ad_reg     <= '0;
            sr_reg     <= '0;
            phase_reg  <= '0;
            env_reg    <= '0;
            stage_reg  <= ENV_ATTACK;
            run_reg    <= 1'b0;
            count_reg  <= '0;
            period_reg <= '0;
        end else begin
            freq_reg   <= freq_next;
            pw_reg     <= pw_next;
            ctrl_reg   <= ctrl_next;
            ad_reg     <= ad_next;
            sr_reg     <= sr_next;
            phase_reg  <= phase_next;
            env_reg    <= env_next;
            stage_reg  <= stage_next;
            run_reg    <= run_next;
            count_reg  <= count_next;
            period_reg <= period_next;
        end
    end

endmodule

@@ rtl/three_voice_tone_generator_unit.sv @@
// ----------------------------------------------------------------------------
// three_voice_tone_generator_unit
// Three-voice tone generator with phase accumulators and ADSR envelopes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                  | tuser
//  s_      | in  | reg_addr[4:0], write_data[12:5]     | operation (0 tick, 1 write)
//  m_      | out | voice1/2/3_level at [6:0],[13:7],[20:14] | -
//
//  One word per cycle unless a tick word waits on a stalled result: an input
//  register feeds single-pass logic updating all voices and the result register.
//  A tick word yields one result word; a write word yields none.
//  Reset (aresetn low, synchronous) clears the valid flags and all voice state.
//  A stalled result holds in the output register; the input side keeps
//  taking words as long as the held word is not blocked behind it.
// ----------------------------------------------------------------------------
module three_voice_tone_generator_unit
    import tvtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_addr[4:0], write_data[12:5], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // voice1_level, voice2_level, voice3_level, pad
);

    logic        in_valid_reg, in_valid_next;
    logic        in_op_reg;
    logic [4:0]  in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg;

    logic        advance;
    logic        is_write;
    logic [1:0]  voice_sel;
    logic [4:0]  voice_base;
    logic [4:0]  off_wide;
    logic [LEVEL_W-1:0] level [VOICE_SLOTS];
    voice_cmd_t  cmd [VOICE_SLOTS];

    assign is_write = (in_op_reg == OP_WRITE);

    // drain the input register when a write, or when the result slot is free
    assign advance  = in_valid_reg && (is_write || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // decode voice slot and offset; slot VOICE_SLOTS means no voice
    always_comb begin
        if (in_addr_reg < VOICE_STRIDE) begin
            voice_sel  = 2'd0;
            voice_base = 5'd0;
        end else if (in_addr_reg < 5'(2 * VOICE_STRIDE)) begin
            voice_sel  = 2'd1;
            voice_base = VOICE_STRIDE;
        end else if (in_addr_reg < FILTER_BASE) begin
            voice_sel  = 2'd2;
            voice_base = 5'(2 * VOICE_STRIDE);
        end else begin
            voice_sel  = 2'd3;
            voice_base = FILTER_BASE;
        end
        off_wide = in_addr_reg - voice_base;
    end

    for (genvar v = 0; v < VOICE_SLOTS; v++) begin : g_voice
        always_comb begin
            cmd[v].tick = advance && !is_write;
            cmd[v].wr   = advance && is_write && (voice_sel == 2'(v));
            cmd[v].off  = off_wide[2:0];
            cmd[v].data = in_data_reg;
        end
        if (v < VOICES) begin : g_on
            tvtg_voice u_voice (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd[v]),
                .level   (level[v])
            );
        end else begin : g_off
            assign level[v] = '0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (advance && !is_write) begin
            m_valid_next = 1'b1;
        end
    end

    // clear the valid flags under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // capture the input word and the result word
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_addr_reg <= s_tdata[4:0];
            in_data_reg <= s_tdata[12:5];
        end
        if (advance && !is_write) begin
            m_data_reg <= {3'b000, level[2], level[1], level[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/tvtg_checker.sv @@
// ----------------------------------------------------------------------------
// tvtg_checker
// Port-level checks for the three-voice tone generator.
// ----------------------------------------------------------------------------
module tvtg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input word changed while stalled");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // each voice level stays within 0..75
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'd75) && (m_tdata[13:7] <= 7'd75)
                     && (m_tdata[20:14] <= 7'd75))
        else $error("voice level out of range");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:21] == 3'b000)
        else $error("result pad bits set");

endmodule

bind three_voice_tone_generator_unit tvtg_checker u_tvtg_checker (.*);
